@@ hw/rtl/cbd_pkg.sv @@
// Shared types and constants for the circular buffer deque.
package cbd_pkg;

	// Store geometry.
	localparam int DEPTH      = 8;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);

	// Operation codes carried by the mode field.
	typedef enum logic [2:0] {
		MODE_PUSH_FRONT = 3'd0,
		MODE_PUSH_REAR  = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_REAR   = 3'd3,
		MODE_PEEK_FRONT = 3'd4,
		MODE_PEEK_REAR  = 3'd5
	} mode_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Command from the controller to the datapath.
	typedef struct packed {
		logic exec;
	} cmd_t;

	// Index of the entry after i, wrapping at the end of the store.
	function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == IDX_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = i + IDX_W'(1);
		end
		return r;
	endfunction

	// Index of the entry before i, wrapping at the start of the store.
	function automatic logic [IDX_W-1:0] prev_slot(input logic [IDX_W-1:0] i);
		logic [IDX_W-1:0] r;
		if (i == '0) begin
			r = IDX_W'(DEPTH - 1);
		end else begin
			r = i - IDX_W'(1);
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/cbd_ctrl.sv @@
// Controller state machine: accepts a transaction and sequences its response.
module cbd_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	output logic         done,
	output cbd_pkg::cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RESP = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// The operation executes on the accept edge; its result shows in the next cycle.
	assign cmd.exec = accept;
	assign busy     = (state_q != S_IDLE);
	assign done     = (state_q == S_RESP);

`ifndef SYNTHESIS
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted transaction did not produce a result");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("new transaction possible while a result is shown");
`endif

endmodule

@@ hw/rtl/cbd_dp.sv @@
// Datapath: circular store, front and rear pointers, and result registers.
module cbd_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cbd_pkg::cmd_t        cmd,
	input  logic [2:0]           mode,
	input  logic signed [31:0]   value,
	output logic signed [31:0]   data,
	output logic [1:0]           status
);

	logic [cbd_pkg::DATA_WIDTH-1:0] store [cbd_pkg::DEPTH];

	logic [cbd_pkg::IDX_W-1:0]      front_q, rear_q;
	logic                           empty_q;
	logic [cbd_pkg::IDX_W-1:0]      front_d, rear_d;
	logic                           empty_d;
	logic                           full;
	logic                           wr_en, rd_en;
	logic [cbd_pkg::IDX_W-1:0]      wr_addr, rd_addr;
	cbd_pkg::status_t               status_d;
	cbd_pkg::status_t               status_q;
	logic [cbd_pkg::DATA_WIDTH-1:0] data_q;
	cbd_pkg::mode_t                 op;

	assign op   = cbd_pkg::mode_t'(mode);
	assign full = !empty_q && (cbd_pkg::next_slot(rear_q) == front_q);

	// Operation decode: pointer updates, store access and status.
	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		empty_d  = empty_q;
		wr_en    = 1'b0;
		wr_addr  = '0;
		rd_en    = 1'b0;
		rd_addr  = front_q;
		status_d = cbd_pkg::ST_OK;
		unique case (op)
			cbd_pkg::MODE_PUSH_FRONT, cbd_pkg::MODE_PUSH_REAR: begin
				if (full) begin
					status_d = cbd_pkg::ST_FULL;
				end else if (empty_q) begin
					front_d = '0;
					rear_d  = '0;
					empty_d = 1'b0;
					wr_en   = 1'b1;
					wr_addr = '0;
				end else if (op == cbd_pkg::MODE_PUSH_FRONT) begin
					front_d = cbd_pkg::prev_slot(front_q);
					wr_en   = 1'b1;
					wr_addr = front_d;
				end else begin
					rear_d  = cbd_pkg::next_slot(rear_q);
					wr_en   = 1'b1;
					wr_addr = rear_d;
				end
			end
			cbd_pkg::MODE_POP_FRONT, cbd_pkg::MODE_POP_REAR,
			cbd_pkg::MODE_PEEK_FRONT, cbd_pkg::MODE_PEEK_REAR: begin
				if (empty_q) begin
					status_d = cbd_pkg::ST_EMPTY;
				end else begin
					rd_en = 1'b1;
					if (op == cbd_pkg::MODE_POP_FRONT || op == cbd_pkg::MODE_PEEK_FRONT) begin
						rd_addr = front_q;
					end else begin
						rd_addr = rear_q;
					end
					// Pops move a pointer; removing the last entry resets both.
					if (op == cbd_pkg::MODE_POP_FRONT || op == cbd_pkg::MODE_POP_REAR) begin
						if (front_q == rear_q) begin
							empty_d = 1'b1;
							front_d = '0;
							rear_d  = '0;
						end else if (op == cbd_pkg::MODE_POP_FRONT) begin
							front_d = cbd_pkg::next_slot(front_q);
						end else begin
							rear_d = cbd_pkg::prev_slot(rear_q);
						end
					end
				end
			end
			default: begin
				// Unused modes leave everything unchanged and report ok.
				status_d = cbd_pkg::ST_OK;
			end
		endcase
	end

	// Pointer and occupancy registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			empty_q <= 1'b1;
		end else if (cmd.exec) begin
			front_q <= front_d;
			rear_q  <= rear_d;
			empty_q <= empty_d;
		end
	end

	// Store write port.
	always_ff @(posedge clk) begin
		if (cmd.exec && wr_en) begin
			store[wr_addr] <= value[cbd_pkg::DATA_WIDTH-1:0];
		end
	end

	// Registered store read and result status.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			data_q   <= rd_en ? store[rd_addr] : '0;
			status_q <= status_d;
		end
	end

	assign data   = data_q;
	assign status = status_q;

`ifndef SYNTHESIS
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (front_q == '0 && rear_q == '0))
		else $error("empty store with pointers away from entry zero");
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && full && (op == cbd_pkg::MODE_PUSH_FRONT || op == cbd_pkg::MODE_PUSH_REAR))
		|=> (status_q == cbd_pkg::ST_FULL && $stable(front_q) && $stable(rear_q)))
		else $error("push into full store changed the pointers");
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && empty_q && (op == cbd_pkg::MODE_POP_FRONT || op == cbd_pkg::MODE_POP_REAR))
		|=> (status_q == cbd_pkg::ST_EMPTY && data_q == '0 && empty_q))
		else $error("pop from empty store returned data or changed state");
`endif

endmodule

@@ hw/rtl/circular_buffer_deque.sv @@
// Top level of the circular buffer deque: controller plus datapath.
// A double-ended queue of 8 words of 32 bits in a circular store. A transaction
// is taken when start is high and busy is low; it carries a mode (push front,
// push rear, pop front, pop rear, peek front, peek rear) and a value for pushes.
// Each transaction gives one result, and a new one is not taken until that
// result has been shown: the operation executes on the accepting edge, and in
// the following cycle done is high for exactly one cycle with data and status,
// while busy is high. The receiver cannot stall, so the result must be
// captured in that cycle. The pacing is set by the registered store read
// and the two-state controller. Status is ok, full (push dropped) or empty
// (nothing returned); data is zero for pushes, errors and unused modes.
module circular_buffer_deque (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         mode,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [31:0] data,
	output logic [1:0]         status
);

	cbd_pkg::cmd_t cmd;

	// Sequencing of each transaction.
	cbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Store, pointers and result registers.
	cbd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.mode   (mode),
		.value  (value),
		.data   (data),
		.status (status)
	);

endmodule
